@@ design/alc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package alc_pkg;

  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned ModeW = 3;

  localparam logic [MinW-1:0] HoursPerDay    = MinW'(24);
  localparam logic [MinW-1:0] MinutesPerHour = MinW'(60);
  localparam logic [HourW-1:0] HourReset     = HourW'(12);

  typedef enum logic [ReqW-1:0] {
    REQ_TICK   = 3'd0,
    REQ_ENC    = 3'd1,
    REQ_SELECT = 3'd2,
    REQ_UP     = 3'd3,
    REQ_DOWN   = 3'd4
  } req_e;

  typedef enum logic [ModeW-1:0] {
    MODE_RUN       = 3'd0,
    MODE_HOUR      = 3'd1,
    MODE_MINUTE    = 3'd2,
    MODE_WAKE_HOUR = 3'd3,
    MODE_WAKE_MIN  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [HourW-1:0] wake_hour;
    logic [MinW-1:0]  wake_minute;
    mode_e            mode;
    logic             alarm;
    logic             led;
    logic [1:0]       prev_code;
  } clk_state_t;

  // quadrature decode, index is {old a, old b, new a, new b}
  function automatic dir_e quad_dir(input logic [3:0] idx);
    dir_e d;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
      4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
      default:                  d = DIR_NONE;
    endcase
    return d;
  endfunction

  // step up wraps to zero, step down clamps at zero
  function automatic logic [MinW-1:0] bump(input logic [MinW-1:0] v, input dir_e d,
                                          input logic [MinW-1:0] limit);
    logic [MinW:0]   inc;
    logic [MinW-1:0] r;
    inc = {1'b0, v} + (MinW+1)'(1);
    r   = v;
    case (d)
      DIR_UP:   r = (inc >= {1'b0, limit}) ? '0 : inc[MinW-1:0];
      DIR_DOWN: begin
        if (v >= limit) r = '0;
        else if (v != '0) r = v - MinW'(1);
      end
      default:  r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/alc_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

module alc_update import alc_pkg::*; (
  input  clk_state_t       cur_i,
  input  logic [ReqW-1:0]  req_i,
  input  logic             enc_a_i,
  input  logic             enc_b_i,
  output clk_state_t       nxt_o
);

  logic [1:0]      code;
  dir_e            enc_dir;
  dir_e            dir;
  logic [MinW:0]   min_inc;
  logic [MinW:0]   hour_inc;
  logic [MinW-1:0] tick_min;
  logic [MinW-1:0] tick_hour;
  logic            adj_en;
  logic [MinW-1:0] adj_val;
  logic [MinW-1:0] adj_res;
  logic [MinW-1:0] adj_lim;

  assign code    = {enc_a_i, enc_b_i};
  assign enc_dir = quad_dir({cur_i.prev_code, code});

  // minute tick with carry into the hour
  always_comb begin
    min_inc  = {1'b0, cur_i.minute} + (MinW+1)'(1);
    hour_inc = {2'b00, cur_i.hour};
    tick_min = min_inc[MinW-1:0];
    if (min_inc >= {1'b0, MinutesPerHour}) begin
      tick_min = '0;
      hour_inc = {2'b00, cur_i.hour} + (MinW+1)'(1);
    end
    tick_hour = (hour_inc >= {1'b0, HoursPerDay}) ? '0 : hour_inc[MinW-1:0];
  end

  // field chosen by the set mode
  always_comb begin
    adj_en  = 1'b1;
    adj_val = '0;
    adj_lim = MinutesPerHour;
    unique case (cur_i.mode)
      MODE_HOUR: begin
        adj_val = {1'b0, cur_i.hour};
        adj_lim = HoursPerDay;
      end
      MODE_MINUTE:    adj_val = cur_i.minute;
      MODE_WAKE_HOUR: begin
        adj_val = {1'b0, cur_i.wake_hour};
        adj_lim = HoursPerDay;
      end
      MODE_WAKE_MIN:  adj_val = cur_i.wake_minute;
      default:        adj_en  = 1'b0;
    endcase
  end

  always_comb begin
    case (req_i)
      REQ_ENC:  dir = enc_dir;
      REQ_UP:   dir = DIR_UP;
      REQ_DOWN: dir = DIR_DOWN;
      default:  dir = DIR_NONE;
    endcase
  end

  assign adj_res = bump(adj_val, dir, adj_lim);

  always_comb begin
    nxt_o = cur_i;
    unique case (req_i)
      REQ_TICK: begin
        nxt_o.minute = tick_min;
        nxt_o.hour   = tick_hour[HourW-1:0];
        if (cur_i.mode == MODE_RUN && tick_hour[HourW-1:0] == cur_i.wake_hour
            && tick_min == cur_i.wake_minute) begin
          nxt_o.alarm = 1'b1;
        end
      end
      REQ_SELECT: begin
        if (cur_i.alarm) begin
          nxt_o.alarm = 1'b0;
        end else begin
          nxt_o.mode = (cur_i.mode >= MODE_WAKE_MIN) ? MODE_RUN
                                                      : mode_e'(cur_i.mode + ModeW'(1));
          nxt_o.led  = ~cur_i.led;
        end
      end
      default: ;
    endcase
    if (req_i == REQ_ENC) nxt_o.prev_code = code;
    if (adj_en && (req_i == REQ_ENC || req_i == REQ_UP || req_i == REQ_DOWN)) begin
      unique case (cur_i.mode)
        MODE_HOUR:      nxt_o.hour        = adj_res[HourW-1:0];
        MODE_MINUTE:    nxt_o.minute      = adj_res;
        MODE_WAKE_HOUR: nxt_o.wake_hour   = adj_res[HourW-1:0];
        default:        nxt_o.wake_minute = adj_res;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/alarm_clock_encoder_set.sv @@
// a request passes the input register, then the state/result register, before its result is valid
// throughput: one request per cycle while out_ready_i stays high
// the state register feeding the update logic is the only datapath loop
// reset: asynchronous active low; time 12:00, alarm 00:00, run mode, alarm and led off,
// encoder code 00, both pipeline stages empty
`timescale 1ns / 1ps
`default_nettype none

module alarm_clock_encoder_set import alc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ReqW-1:0]   req_type_i,
  input  wire logic              enc_a_i,
  input  wire logic              enc_b_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [HourW-1:0]       hour_now_o,
  output logic [MinW-1:0]        minute_now_o,
  output logic [HourW-1:0]       wake_hour_o,
  output logic [MinW-1:0]        wake_minute_o,
  output logic [ModeW-1:0]       set_mode_o,
  output logic                   alarm_active_o,
  output logic                   mode_led_o
);

  // input register
  logic            in_valid_q;
  logic [ReqW-1:0] req_q;
  logic            enc_a_q;
  logic            enc_b_q;

  // clock state doubles as the result register: it only moves when a result is loaded
  clk_state_t      state_q;
  clk_state_t      state_d;
  logic            out_valid_q;

  logic            out_free;
  logic            advance;

  // result slot can take a new value if empty or being drained this cycle
  assign out_free   = ~out_valid_q | out_ready_i;
  assign advance    = in_valid_q & out_free;
  assign in_ready_o = ~in_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q   <= req_type_i;
      enc_a_q <= enc_a_i;
      enc_b_q <= enc_b_i;
    end
  end

  // next clock state for the request held in the input register
  alc_update u_update (
    .cur_i   (state_q),
    .req_i   (req_q),
    .enc_a_i (enc_a_q),
    .enc_b_i (enc_b_q),
    .nxt_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hour        <= HourReset;
      state_q.minute      <= '0;
      state_q.wake_hour   <= '0;
      state_q.wake_minute <= '0;
      state_q.mode        <= MODE_RUN;
      state_q.alarm       <= 1'b0;
      state_q.led         <= 1'b0;
      state_q.prev_code   <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hour_now_o     = state_q.hour;
  assign minute_now_o   = state_q.minute;
  assign wake_hour_o    = state_q.wake_hour;
  assign wake_minute_o  = state_q.wake_minute;
  assign set_mode_o     = state_q.mode;
  assign alarm_active_o = state_q.alarm;
  assign mode_led_o     = state_q.led;

  // the clock state only changes when a request is retired into the result slot
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("clock state changed without a retired request");

  // the alarm is only raised by a minute tick in run mode
  a_alarm_raise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.alarm) |-> $past(advance) && $past(req_q) == REQ_TICK
                             && $past(state_q.mode) == MODE_RUN)
    else $error("alarm raised by something other than a run mode tick");

  // every mode step toggles the led
  a_led_follows_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode != $past(state_q.mode) |-> state_q.led != $past(state_q.led))
    else $error("mode stepped without led toggle");

  // a result is only pending after a retired request
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result valid without a retired request");

endmodule

`default_nettype wire

@@ verif/alarm_clock_encoder_set_test.sv @@
`timescale 1ns / 1ps

module alarm_clock_encoder_set_test;
  import alc_pkg::*;

  // request codes the block has no action for
  localparam logic [ReqW-1:0] ReqSpareFirst = 3'd5;
  localparam logic [ReqW-1:0] ReqSpareLast  = 3'd7;

  localparam int ItemCount  = 1450;
  localparam int IdlePct    = 26;
  // window of cycles in which neither side idles
  localparam int CalmStart  = 500;
  localparam int CalmEnd    = 1000;
  localparam int DrainTicks = 8;

  typedef struct {
    logic [ReqW-1:0] req;
    logic            a;
    logic            b;
    bit              hold;    // sender waits for all results before this one
  } request_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [ReqW-1:0]   req_type_i  = REQ_TICK;
  logic              enc_a_i     = 1'b0;
  logic              enc_b_i     = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [HourW-1:0]  hour_now_o;
  logic [MinW-1:0]   minute_now_o;
  logic [HourW-1:0]  wake_hour_o;
  logic [MinW-1:0]   wake_minute_o;
  logic [ModeW-1:0]  set_mode_o;
  logic              alarm_active_o;
  logic              mode_led_o;

  request_t   request_q[$];   // requests not yet driven
  clk_state_t readout_q[$];   // predicted clock readouts, oldest first
  request_t   next_req;
  clk_state_t clock_model;    // clock as seen by accepted requests
  clk_state_t clock_plan;     // clock as seen by generated requests
  bit         req_busy;       // a request is on the bus, not yet taken
  bit         hold_next;
  int         errors;
  int         accepted;
  int         alarms_raised;
  int         alarms_cleared;
  int         rollovers;
  int unsigned cycle_n;

  alarm_clock_encoder_set u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .enc_a_i        (enc_a_i),
    .enc_b_i        (enc_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hour_now_o     (hour_now_o),
    .minute_now_o   (minute_now_o),
    .wake_hour_o    (wake_hour_o),
    .wake_minute_o  (wake_minute_o),
    .set_mode_o     (set_mode_o),
    .alarm_active_o (alarm_active_o),
    .mode_led_o     (mode_led_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_n <= cycle_n + 1;

  function automatic bit calm();
    return cycle_n >= CalmStart && cycle_n < CalmEnd;
  endfunction

  // ------------------------------------------------------------------
  // clock predictor
  // ------------------------------------------------------------------

  // encoder codes walk 00 -> 10 -> 11 -> 01 -> 00 when turned up
  function automatic int ring_pos(logic [1:0] code);
    case (code)
      2'b00:   return 0;
      2'b10:   return 1;
      2'b11:   return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [1:0] ring_code(int pos);
    case (pos & 3)
      0:       return 2'b00;
      1:       return 2'b10;
      2:       return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  // one notch forward is +1, one back is -1, a jump of two is ignored
  function automatic int quad_step(logic [1:0] old_code, logic [1:0] new_code);
    int d;
    d = (ring_pos(new_code) - ring_pos(old_code)) & 3;
    if (d == 1) return 1;
    if (d == 3) return -1;
    return 0;
  endfunction

  // up wraps at the limit, down sticks at zero
  function automatic int step_field(int v, int dir, int limit);
    if (dir > 0) begin
      v = v + 1;
      if (v >= limit) v = 0;
    end else if (dir < 0) begin
      if (v >= limit) v = 0;
      else if (v > 0) v = v - 1;
    end
    return v;
  endfunction

  function automatic clk_state_t advance_clock(clk_state_t s, logic [ReqW-1:0] req,
                                               logic a, logic b);
    int hr;
    int mn;
    int wh;
    int wm;
    int dir;
    hr  = s.hour;
    mn  = s.minute;
    wh  = s.wake_hour;
    wm  = s.wake_minute;
    dir = 0;
    case (req)
      REQ_TICK: begin
        mn = mn + 1;
        if (mn >= int'(MinutesPerHour)) begin
          mn = 0;
          hr = hr + 1;
        end
        if (hr >= int'(HoursPerDay)) hr = 0;
        // alarm only fires in run mode
        if (s.mode == MODE_RUN && hr == wh && mn == wm) s.alarm = 1'b1;
      end
      REQ_ENC: begin
        dir = quad_step(s.prev_code, {a, b});
        s.prev_code = {a, b};
      end
      REQ_SELECT: begin
        // a raised alarm eats the press
        if (s.alarm) s.alarm = 1'b0;
        else begin
          s.mode = (s.mode >= MODE_WAKE_MIN) ? MODE_RUN : mode_e'(s.mode + 1);
          s.led  = ~s.led;
        end
      end
      REQ_UP:   dir = 1;
      REQ_DOWN: dir = -1;
      default: ;
    endcase
    case (s.mode)
      MODE_HOUR:      hr = step_field(hr, dir, int'(HoursPerDay));
      MODE_MINUTE:    mn = step_field(mn, dir, int'(MinutesPerHour));
      MODE_WAKE_HOUR: wh = step_field(wh, dir, int'(HoursPerDay));
      MODE_WAKE_MIN:  wm = step_field(wm, dir, int'(MinutesPerHour));
      default: ;
    endcase
    s.hour        = HourW'(hr);
    s.minute      = MinW'(mn);
    s.wake_hour   = HourW'(wh);
    s.wake_minute = MinW'(wm);
    return s;
  endfunction

  function automatic clk_state_t clock_at_reset();
    clk_state_t s;
    s.hour        = HourReset;
    s.minute      = '0;
    s.wake_hour   = '0;
    s.wake_minute = '0;
    s.mode        = MODE_RUN;
    s.alarm       = 1'b0;
    s.led         = 1'b0;
    s.prev_code   = 2'b00;
    return s;
  endfunction

  // ------------------------------------------------------------------
  // stimulus planning, tracks the clock the requests will produce
  // ------------------------------------------------------------------

  task automatic push_request(logic [ReqW-1:0] req, logic a, logic b);
    request_t r;
    r.req  = req;
    r.a    = a;
    r.b    = b;
    r.hold = hold_next;
    hold_next = 1'b0;
    request_q.push_back(r);
    clock_plan = advance_clock(clock_plan, req, a, b);
  endtask

  // button requests carry random encoder levels, which must be ignored
  task automatic push_button(logic [ReqW-1:0] req);
    push_request(req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic steer_mode(mode_e target);
    while (clock_plan.mode != target) push_button(REQ_SELECT);
  endtask

  function automatic int field_value(clk_state_t s);
    case (s.mode)
      MODE_HOUR:      return s.hour;
      MODE_MINUTE:    return s.minute;
      MODE_WAKE_HOUR: return s.wake_hour;
      default:        return s.wake_minute;
    endcase
  endfunction

  // walks the field of the current set mode to the target, the short way round
  task automatic dial_field(int target);
    int  cur;
    int  lim;
    bit  up;
    logic [1:0] nc;
    while (field_value(clock_plan) != target) begin
      cur = field_value(clock_plan);
      lim = (clock_plan.mode == MODE_HOUR || clock_plan.mode == MODE_WAKE_HOUR) ?
            int'(HoursPerDay) : int'(MinutesPerHour);
      up  = (cur < target) || ((target + lim - cur) < (cur - target));
      if ($urandom_range(0, 99) < 3) push_button(REQ_TICK);
      else if ($urandom_range(0, 1)) push_button(up ? REQ_UP : REQ_DOWN);
      else begin
        nc = ring_code(ring_pos(clock_plan.prev_code) + (up ? 1 : 3));
        push_request(REQ_ENC, nc[1], nc[0]);
      end
    end
  endtask

  // set the alarm a few minutes ahead, run into it, then clear it in most runs
  task automatic chase_alarm();
    int lead;
    int th;
    int tm;
    int n;
    lead = $urandom_range(1, 4);
    if ($urandom_range(0, 99) < 35) begin
      // park the time near the top of the hour, mostly just before midnight
      steer_mode(MODE_HOUR);
      dial_field(($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23);
      steer_mode(MODE_MINUTE);
      dial_field($urandom_range(54, 59));
    end
    steer_mode(MODE_WAKE_HOUR);
    tm = clock_plan.minute + lead;
    th = clock_plan.hour;
    if (tm >= int'(MinutesPerHour)) begin
      tm = tm - int'(MinutesPerHour);
      th = (th + 1) % int'(HoursPerDay);
    end
    dial_field(th);
    steer_mode(MODE_WAKE_MIN);
    dial_field(tm);
    steer_mode(MODE_RUN);
    n = 0;
    while (!clock_plan.alarm && n < 70) begin
      push_button(REQ_TICK);
      n++;
    end
    // the alarm keeps sounding through ticks and ignored adjusts
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       push_button(REQ_TICK);
        1:       push_button(REQ_UP);
        2:       push_button(REQ_DOWN);
        default: push_request(REQ_ENC, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
    end
    if ($urandom_range(0, 99) < 85) push_button(REQ_SELECT);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      push_request(ReqW'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endtask

  // ------------------------------------------------------------------
  // driver: requests change on the falling edge, taken on the rising edge
  // ------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni && !req_busy) begin
      if (request_q.size() == 0 ||
          (request_q[0].hold && readout_q.size() != 0) ||
          (!calm() && $urandom_range(0, 99) < IdlePct)) begin
        in_valid_i <= 1'b0;
      end else begin
        next_req    = request_q.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= next_req.req;
        enc_a_i    <= next_req.a;
        enc_b_i    <= next_req.b;
        req_busy    = 1'b1;
      end
    end
  end

  // accepted request: advance the predicted clock and queue its readout
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      clk_state_t prior;
      prior       = clock_model;
      clock_model = advance_clock(clock_model, req_type_i, enc_a_i, enc_b_i);
      readout_q.push_back(clock_model);
      if (!prior.alarm && clock_model.alarm) alarms_raised++;
      if (prior.alarm && !clock_model.alarm) alarms_cleared++;
      if (req_type_i == REQ_TICK && clock_model.hour == '0 && clock_model.minute == '0)
        rollovers++;
      accepted++;
      req_busy = 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // monitor: random back-pressure, compare each readout in order
  // ------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= calm() || ($urandom_range(0, 99) >= IdlePct);
  end

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      clk_state_t want;
      if (readout_q.size() == 0) begin
        $display("%0t ns: readout with no request pending, expected none, actual %0d:%0d",
                 $time, hour_now_o, minute_now_o);
        errors++;
      end else begin
        want = readout_q.pop_front();
        check_field("hour_now",     want.hour,        hour_now_o);
        check_field("minute_now",   want.minute,      minute_now_o);
        check_field("wake_hour",    want.wake_hour,   wake_hour_o);
        check_field("wake_minute",  want.wake_minute, wake_minute_o);
        check_field("set_mode",     want.mode,        set_mode_o);
        check_field("alarm_active", want.alarm,       alarm_active_o);
        check_field("mode_led",     want.led,         mode_led_o);
      end
    end
  end

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------

  initial begin
    clock_model = clock_at_reset();
    clock_plan  = clock_at_reset();

    // request codes with no action still report the clock
    for (int c = int'(ReqSpareFirst); c <= int'(ReqSpareLast); c++)
      push_request(ReqW'(c), c[0], c[1]);
    // adjusts in run mode change nothing, encoder code is still tracked
    push_request(REQ_UP, 1'b1, 1'b1);
    push_request(REQ_DOWN, 1'b0, 1'b0);
    push_request(REQ_ENC, 1'b1, 1'b0);
    push_request(REQ_TICK, 1'b0, 1'b0);
    // hour set mode, tick still advances the time
    push_request(REQ_SELECT, 1'b0, 1'b0);
    push_request(REQ_DOWN, 1'b0, 1'b0);
    push_request(REQ_UP, 1'b0, 1'b0);
    push_request(REQ_TICK, 1'b1, 1'b1);
    // minute set mode, one encoder notch up
    push_request(REQ_SELECT, 1'b0, 1'b0);
    push_request(REQ_DOWN, 1'b0, 1'b0);
    push_request(REQ_ENC, 1'b1, 1'b1);
    // alarm hour at zero: down sticks, a two-bit jump is ignored
    push_request(REQ_SELECT, 1'b0, 1'b0);
    push_request(REQ_DOWN, 1'b0, 1'b0);
    push_request(REQ_ENC, 1'b0, 1'b0);
    push_request(REQ_UP, 1'b0, 1'b0);
    // alarm minute at zero: down by button and by encoder both stick
    push_request(REQ_SELECT, 1'b0, 1'b0);
    push_request(REQ_DOWN, 1'b0, 1'b0);
    push_request(REQ_ENC, 1'b0, 1'b1);
    push_request(REQ_ENC, 1'b1, 1'b1);
    // back to run mode
    push_request(REQ_SELECT, 1'b0, 1'b0);

    // random part, opened by a full drain of the directed readouts
    hold_next = 1'b1;
    while (request_q.size() < ItemCount) begin
      if ($urandom_range(0, 99) < 3) hold_next = 1'b1;
      if ($urandom_range(0, 99) < 70) chase_alarm();
      else noise_burst();
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || req_busy || readout_q.size() != 0) @(posedge clk_i);
    // keep clocking to catch any stray readout
    repeat (DrainTicks) @(posedge clk_i);

    $display("covered %0d requests, all request codes and set modes, encoder and buttons",
             accepted);
    $display("alarms raised %0d, cleared %0d, midnight rollovers %0d, mismatches %0d",
             alarms_raised, alarms_cleared, rollovers, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d requests and %0d readouts outstanding",
             request_q.size(), readout_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/alc_pkg.sv
design/alc_update.sv
design/alarm_clock_encoder_set.sv
verif/alarm_clock_encoder_set_test.sv
